// ===== hdl/msctt_pkg.sv =====
// Shared types and codes for the multi-slot countdown timer table.
// Holds command, slot mode, reply status and controller state encodings.
// No dependencies.
`default_nettype none

package msctt_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 3;

  // Request kinds carried on the input side
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD     = 3'd0,
    ACT_CANCEL  = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_PAUSE   = 3'd3,
    ACT_RESUME  = 3'd4,
    ACT_TICK    = 3'd5
  } action_t;

  // Per-slot mode
  typedef enum logic [1:0] {
    MODE_RUNNING   = 2'd0,
    MODE_FINISHED  = 2'd1,
    MODE_PAUSED    = 2'd2,
    MODE_CANCELLED = 2'd3
  } mode_t;

  // Reply status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SPACE  = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FINISHED  = 3'd3,
    STAT_CANCELLED = 3'd4
  } status_t;

  // Result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_SCAN  = 2'd2,
    ST_FLUSH = 2'd3
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/multi_slot_countdown_timer_table.sv =====
// Multi-slot countdown timer table: a fixed table of one-shot timer slots. A command request
// (add, cancel, release, pause, resume) is accepted in IDLE, then executed in EXEC once the result
// register is free, and gives one reply. A tick request walks the slots in index order through the
// registered count memory read, one slot per cycle while the result side does not stall; each
// running slot that reaches zero gives a fire event, the last one marked with tlast. Slot used
// and mode flags live in flip-flops cleared at reset; counts and tags live in memories, written
// by add before any read, so no clearing pass is needed.
// Depends on msctt_pkg.
`default_nettype none

module multi_slot_countdown_timer_table #(
  parameter int SLOTS       = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int TAG_WIDTH   = 32,
  localparam int ID_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int IN_BITS    = ID_W + COUNT_WIDTH + TAG_WIDTH,
  localparam int IN_DW      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = msctt_pkg::STATUS_W + ID_W + TAG_WIDTH,
  localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input request channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [IN_DW-1:0]               in_tdata,   // slot_id, seconds, job_tag, zero pad
  input  wire logic [msctt_pkg::ACTION_W-1:0] in_tuser,   // action
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [OUT_DW-1:0]                   out_tdata,  // status, result_slot, fired_tag, pad
  output logic                                out_tuser,  // kind
  output logic                                out_tlast   // last
);

  import msctt_pkg::*;

  // Slot state flags
  logic [SLOTS-1:0]       used_r;
  mode_t                  mode_r [SLOTS];

  // Count and tag memories
  logic [COUNT_WIDTH-1:0] cnt_mem [SLOTS];
  logic [TAG_WIDTH-1:0]   tag_mem [SLOTS];
  logic [COUNT_WIDTH-1:0] cnt_q_r;
  logic [TAG_WIDTH-1:0]   tag_q_r;

  // Controller
  state_t                 state_r, state_nxt;

  // Latched request
  action_t                act_r;
  logic [ID_W-1:0]        id_r;
  logic [COUNT_WIDTH-1:0] secs_r;
  logic [TAG_WIDTH-1:0]   tag_r;

  // Scan pipeline
  logic [ID_W:0]          rd_idx_r;
  logic                   b_vld_r;
  logic [ID_W-1:0]        b_idx_r;

  // Held fire event, sent once the next one (or the end of the scan) is known
  logic                   pend_vld_r;
  logic [ID_W-1:0]        pend_idx_r;
  logic [TAG_WIDTH-1:0]   pend_tag_r;

  // Output register
  logic                   out_valid_r;
  logic                   out_kind_r;
  status_t                out_status_r;
  logic [ID_W-1:0]        out_slot_r;
  logic [TAG_WIDTH-1:0]   out_tag_r;
  logic                   out_last_r;

  // Combinational helpers
  logic                   out_free;
  logic                   is_cmd;
  logic                   id_ok;
  logic [ID_W-1:0]        id_idx;
  logic                   id_used;
  mode_t                  id_mode;
  logic                   free_found;
  logic [ID_W-1:0]        free_idx;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   b_elig;
  logic                   b_fire;
  logic                   stall;
  logic                   scan_more;

  // Control strobes
  logic                   slot_we;
  logic [ID_W-1:0]        slot_wa;
  logic                   slot_used_wd;
  mode_t                  slot_mode_wd;
  logic                   cnt_we;
  logic [ID_W-1:0]        cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;
  logic                   tag_we;
  logic                   rd_en;
  logic                   scan_start;
  logic                   scan_adv;
  logic                   pend_load;
  logic                   pend_clr;
  logic                   push;
  logic                   push_kind;
  status_t                push_status;
  logic [ID_W-1:0]        push_slot;
  logic [TAG_WIDTH-1:0]   push_tag;
  logic                   push_last;

  // Derive lookups on the latched request
  assign out_free  = !out_valid_r || out_tready;
  assign is_cmd    = (act_r == ACT_ADD) || (act_r == ACT_CANCEL) || (act_r == ACT_RELEASE) ||
                     (act_r == ACT_PAUSE) || (act_r == ACT_RESUME);
  assign id_ok     = ((ID_W+1)'(id_r) < (ID_W+1)'(SLOTS));
  assign id_idx    = id_ok ? id_r : '0;
  assign id_used   = id_ok && used_r[id_idx];
  assign id_mode   = mode_r[id_idx];

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = ID_W'(i);
      end
    end
  end

  // Decrement the slot under scan, saturating at zero
  assign cnt_dec   = (cnt_q_r != '0) ? (cnt_q_r - COUNT_WIDTH'(1)) : '0;
  assign b_elig    = b_vld_r && used_r[b_idx_r] && (mode_r[b_idx_r] == MODE_RUNNING);
  assign b_fire    = b_elig && (cnt_dec == '0);
  assign stall     = (state_r == ST_SCAN) && b_fire && pend_vld_r && !out_free;
  assign scan_more = (rd_idx_r < (ID_W+1)'(SLOTS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (act_r == ACT_TICK) begin
          state_nxt = ST_SCAN;
        end else if (!is_cmd || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall && !scan_more) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_vld_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    in_tready    = 1'b0;
    slot_we      = 1'b0;
    slot_wa      = '0;
    slot_used_wd = 1'b0;
    slot_mode_wd = MODE_RUNNING;
    cnt_we       = 1'b0;
    cnt_wa       = '0;
    cnt_wd       = '0;
    tag_we       = 1'b0;
    rd_en        = 1'b0;
    scan_start   = 1'b0;
    scan_adv     = 1'b0;
    pend_load    = 1'b0;
    pend_clr     = 1'b0;
    push         = 1'b0;
    push_kind    = KIND_REPLY;
    push_status  = STAT_OK;
    push_slot    = '0;
    push_tag     = '0;
    push_last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EXEC: begin
        if (act_r == ACT_TICK) begin
          scan_start = 1'b1;
        end else if (is_cmd && out_free) begin
          push = 1'b1;
          if (act_r == ACT_ADD) begin
            if (free_found) begin
              slot_we      = 1'b1;
              slot_wa      = free_idx;
              slot_used_wd = 1'b1;
              slot_mode_wd = MODE_RUNNING;
              cnt_we       = 1'b1;
              cnt_wa       = free_idx;
              cnt_wd       = secs_r;
              tag_we       = 1'b1;
              push_slot    = free_idx;
            end else begin
              push_status  = STAT_NO_SPACE;
            end
          end else if (!id_used) begin
            push_status = STAT_EMPTY;
          end else begin
            slot_wa      = id_idx;
            slot_used_wd = 1'b1;
            case (act_r)
              ACT_CANCEL: begin
                if (id_mode == MODE_FINISHED) begin
                  push_status = STAT_FINISHED;
                end else if (id_mode == MODE_CANCELLED) begin
                  push_status = STAT_CANCELLED;
                end else begin
                  slot_we      = 1'b1;
                  slot_mode_wd = MODE_CANCELLED;
                end
              end
              ACT_RELEASE: begin
                slot_we      = 1'b1;
                slot_used_wd = 1'b0;
                slot_mode_wd = MODE_RUNNING;
              end
              ACT_PAUSE: begin
                slot_we      = 1'b1;
                slot_mode_wd = MODE_PAUSED;
              end
              default: begin
                slot_we      = 1'b1;
                slot_mode_wd = MODE_RUNNING;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          scan_adv = 1'b1;
          rd_en    = scan_more;
          // Write back the decremented count
          if (b_elig) begin
            cnt_we = 1'b1;
            cnt_wa = b_idx_r;
            cnt_wd = cnt_dec;
          end
          // Mark finished, send the held event and hold this one
          if (b_fire) begin
            slot_we      = 1'b1;
            slot_wa      = b_idx_r;
            slot_used_wd = 1'b1;
            slot_mode_wd = MODE_FINISHED;
            pend_load    = 1'b1;
            if (pend_vld_r) begin
              push      = 1'b1;
              push_kind = KIND_EVENT;
              push_slot = pend_idx_r;
              push_tag  = pend_tag_r;
              push_last = 1'b0;
            end
          end
        end
      end
      ST_FLUSH: begin
        // Send the final event with last set
        if (pend_vld_r && out_free) begin
          pend_clr  = 1'b1;
          push      = 1'b1;
          push_kind = KIND_EVENT;
          push_slot = pend_idx_r;
          push_tag  = pend_tag_r;
          push_last = 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Count and tag memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (rd_en) cnt_q_r <= cnt_mem[rd_idx_r[ID_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[free_idx] <= tag_r;
    if (rd_en) tag_q_r <= tag_mem[rd_idx_r[ID_W-1:0]];
  end

  // Controller, slot flags and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      for (int i = 0; i < SLOTS; i++) mode_r[i] <= MODE_RUNNING;
      rd_idx_r    <= '0;
      b_vld_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (slot_we) begin
        used_r[slot_wa] <= slot_used_wd;
        mode_r[slot_wa] <= slot_mode_wd;
      end
      // Advance the scan pointer
      if (scan_start) begin
        rd_idx_r <= '0;
        b_vld_r  <= 1'b0;
      end else if (scan_adv) begin
        b_vld_r <= scan_more;
        if (scan_more) rd_idx_r <= rd_idx_r + (ID_W+1)'(1);
      end
      if (pend_load) begin
        pend_vld_r <= 1'b1;
      end else if (pend_clr || scan_start) begin
        pend_vld_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= action_t'(in_tuser);
      id_r   <= in_tdata[ID_W-1:0];
      secs_r <= in_tdata[ID_W +: COUNT_WIDTH];
      tag_r  <= in_tdata[ID_W + COUNT_WIDTH +: TAG_WIDTH];
    end
    if (scan_adv) b_idx_r <= rd_idx_r[ID_W-1:0];
    if (pend_load) begin
      pend_idx_r <= b_idx_r;
      pend_tag_r <= tag_q_r;
    end
    if (push) begin
      out_kind_r   <= push_kind;
      out_status_r <= push_status;
      out_slot_r   <= push_slot;
      out_tag_r    <= push_tag;
      out_last_r   <= push_last;
    end
  end

  // Drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_tag_r, out_slot_r, out_status_r});
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // A held fire event exists only while a tick is being processed
  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_EXEC) |-> !pend_vld_r)
    else $error("held fire event outside a tick");

  // A stalled scan keeps the slot under work in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (b_vld_r && $stable(b_idx_r)))
    else $error("scan advanced while stalled");

  // Every fire event sent names a used, finished slot
  a_event_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_kind == KIND_EVENT)) |=>
      (used_r[out_slot_r] && (mode_r[out_slot_r] == MODE_FINISHED)))
    else $error("fire event for a slot that is not finished");
`endif

endmodule

`default_nettype wire

// ===== dv/multi_slot_countdown_timer_table_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the multi-slot countdown timer table: bursty request driver,
// stalling result sink and an in-bench slot table that predicts every reply and fire event.
// Depends on msctt_pkg and multi_slot_countdown_timer_table.
module multi_slot_countdown_timer_table_test;
  import msctt_pkg::*;

  localparam int TABLE_SLOTS  = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 360;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [3:0]          slot_id;
    logic [15:0]         seconds;
    logic [31:0]         job_tag;
  } timer_req_t;

  typedef struct {
    logic        kind;
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // slot_id, seconds, job_tag, zero pad
  logic [2:0]  in_tuser = '0;   // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // status, result_slot, fired_tag, pad
  logic        out_tuser;       // kind
  logic        out_tlast;       // last

  // Shadow of the slot table, advanced on every accepted request
  logic        slot_used_q [TABLE_SLOTS];
  mode_t       slot_mode_q [TABLE_SLOTS];
  logic [15:0] slot_count_q[TABLE_SLOTS];
  logic [31:0] slot_tag_q  [TABLE_SLOTS];

  timer_req_t    pending_q[$];
  timer_result_t outcome_q[$];
  timer_req_t    cur_req;
  logic          req_in_flight = 1'b0;
  logic          burst_steady = 1'b0;
  logic          hold_req = 1'b0;
  int            burst_left = 1;
  int            gap_left = 0;
  int            hold_cnt = 0;
  logic [31:0]   rx_cycle = '0;
  logic [7:0]    stall_lfsr = 8'h5D;
  int            fail_count = 0;

  multi_slot_countdown_timer_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_used_q[i]  = 1'b0;
      slot_mode_q[i]  = MODE_RUNNING;
      slot_count_q[i] = '0;
      slot_tag_q[i]   = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one request to the shadow table and queue the results it causes
  task automatic advance_timer_table(input timer_req_t rq);
    timer_result_t r;
    int free_slot;
    int fires;
    r.kind   = KIND_REPLY;
    r.status = STAT_OK;
    r.slot   = '0;
    r.tag    = '0;
    r.last   = 1'b1;
    free_slot = -1;
    fires = 0;
    case (rq.action)
      ACT_ADD: begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (!slot_used_q[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          r.status = STAT_NO_SPACE;
        end else begin
          slot_used_q[free_slot]  = 1'b1;
          slot_mode_q[free_slot]  = MODE_RUNNING;
          slot_count_q[free_slot] = rq.seconds;
          slot_tag_q[free_slot]   = rq.job_tag;
          r.slot = free_slot[3:0];
        end
        outcome_q.push_back(r);
      end
      ACT_CANCEL, ACT_RELEASE, ACT_PAUSE, ACT_RESUME: begin
        if (!slot_used_q[rq.slot_id]) begin
          r.status = STAT_EMPTY;
        end else if (rq.action == ACT_CANCEL && slot_mode_q[rq.slot_id] == MODE_FINISHED) begin
          r.status = STAT_FINISHED;
        end else if (rq.action == ACT_CANCEL &&
                     slot_mode_q[rq.slot_id] == MODE_CANCELLED) begin
          r.status = STAT_CANCELLED;
        end else begin
          case (rq.action)
            ACT_CANCEL: slot_mode_q[rq.slot_id] = MODE_CANCELLED;
            ACT_RELEASE: begin
              slot_used_q[rq.slot_id] = 1'b0;
              slot_mode_q[rq.slot_id] = MODE_RUNNING;
            end
            ACT_PAUSE: slot_mode_q[rq.slot_id] = MODE_PAUSED;
            default: slot_mode_q[rq.slot_id] = MODE_RUNNING;
          endcase
        end
        outcome_q.push_back(r);
      end
      ACT_TICK: begin
        // Count running slots down, saturating at zero; fire each one that sits at zero
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_used_q[i] && slot_mode_q[i] == MODE_RUNNING) begin
            if (slot_count_q[i] != 0) slot_count_q[i] = slot_count_q[i] - 16'd1;
            if (slot_count_q[i] == 0) begin
              slot_mode_q[i] = MODE_FINISHED;
              r.kind = KIND_EVENT;
              r.slot = i[3:0];
              r.tag  = slot_tag_q[i];
              r.last = 1'b0;
              outcome_q.push_back(r);
              fires++;
            end
          end
        end
        if (fires > 0) outcome_q[outcome_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Offer queued requests in bursts with random gaps between them
  always @(posedge clk) begin : request_driver
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_timer_table(cur_req);
        req_in_flight = 1'b0;
      end
      offer = in_tvalid && !in_tready;
      if (!offer) begin
        if (gap_left > 0 && !burst_steady) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          cur_req = pending_q.pop_front();
          req_in_flight = 1'b1;
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_tvalid <= offer;
      in_tdata  <= {4'b0, cur_req.job_tag, cur_req.seconds, cur_req.slot_id};
      in_tuser  <= cur_req.action;
    end
  end

  // Stall the result side on a pattern chosen by bits 9:8 of the cycle counter
  always @(posedge clk) begin : result_sink
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      stall_lfsr = {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
      case (rx_cycle[9:8])
        2'd0: rdy = 1'b1;
        2'd1: rdy = ($urandom_range(0, 99) < 70);
        2'd2: rdy = stall_lfsr[0] | stall_lfsr[3];
        default: rdy = (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
      endcase
      // Hold off for one long stretch once asked
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        hold_cnt++;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_monitor
    timer_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result: kind %0d status %0d slot %0d tag %0h",
               out_tuser, out_tdata[2:0], out_tdata[6:3], out_tdata[38:7]);
        fail_count++;
      end else begin
        exp_r = outcome_q.pop_front();
        check_field("kind", exp_r.kind, out_tuser);
        check_field("status", exp_r.status, out_tdata[2:0]);
        check_field("result_slot", exp_r.slot, out_tdata[6:3]);
        check_field("fired_tag", exp_r.tag, out_tdata[38:7]);
        check_field("last", exp_r.last, out_tlast);
      end
    end
  end

  task automatic queue_req(input logic [2:0] action, input logic [3:0] id,
                           input logic [15:0] secs, input logic [31:0] tag);
    timer_req_t rq;
    rq.action  = action;
    rq.slot_id = id;
    rq.seconds = secs;
    rq.job_tag = tag;
    pending_q.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || req_in_flight) @(posedge clk);
  endtask

  task automatic wait_settled();
    wait_drained();
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_used_slot();
    int used_ids[$];
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (slot_used_q[i]) used_ids.push_back(i);
    if (used_ids.size() == 0) return 4'($urandom_range(0, TABLE_SLOTS - 1));
    return 4'(used_ids[$urandom_range(0, used_ids.size() - 1)]);
  endfunction

  function automatic logic [2:0] pick_slot_command(input int n_used);
    int r;
    r = $urandom_range(0, 99);
    if (n_used == TABLE_SLOTS || r < 35) return ACT_RELEASE;
    if (r < 55) return ACT_CANCEL;
    if (r < 75) return ACT_PAUSE;
    return ACT_RESUME;
  endfunction

  initial begin : stimulus
    int issued;
    int n_used;
    int r;
    logic [15:0] secs;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Commands on an empty table, and an idle tick
    queue_req(ACT_CANCEL, 4'd0, 16'd0, 32'd0);
    queue_req(ACT_RELEASE, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(ACT_PAUSE, 4'd3, 16'd0, 32'd0);
    queue_req(ACT_RESUME, 4'd7, 16'd0, 32'd0);
    queue_req(ACT_TICK, 4'd0, 16'd0, 32'd0);
    // Extreme counts and tags; zero count fires on the first tick
    queue_req(ACT_ADD, 4'd0, 16'd0, 32'hFFFF_FFFF);
    queue_req(ACT_ADD, 4'd15, 16'hFFFF, 32'h0);
    queue_req(ACT_ADD, 4'd0, 16'd2, 32'hA5A5_5A5A);
    queue_req(ACT_ADD, 4'd0, 16'd1, 32'h5A5A_A5A5);
    queue_req(ACT_TICK, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    // Cancel on finished, running and cancelled slots
    queue_req(ACT_CANCEL, 4'd0, 16'd0, 32'd0);
    queue_req(ACT_CANCEL, 4'd2, 16'd0, 32'd0);
    queue_req(ACT_CANCEL, 4'd2, 16'd0, 32'd0);
    queue_req(ACT_PAUSE, 4'd1, 16'd0, 32'd0);
    // Resume a finished slot at zero: it fires again
    queue_req(ACT_RESUME, 4'd0, 16'd0, 32'd0);
    queue_req(ACT_TICK, 4'd0, 16'd0, 32'd0);
    queue_req(ACT_PAUSE, 4'd3, 16'd0, 32'd0);
    queue_req(ACT_RELEASE, 4'd2, 16'd0, 32'd0);
    // Unused action codes change nothing
    queue_req(ACT_UNUSED_6, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(ACT_UNUSED_7, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(ACT_TICK, 4'd0, 16'd0, 32'd0);
    wait_settled();

    // Fill the table behind a long receiver hold-off: no space, then sixteen fires
    hold_req = 1'b1;
    burst_steady = 1'b1;
    for (int i = 0; i < TABLE_SLOTS; i++) queue_req(ACT_RELEASE, 4'(i), 16'd0, 32'd0);
    for (int i = 0; i <= TABLE_SLOTS; i++) queue_req(ACT_ADD, 4'd0, 16'd1, $urandom);
    queue_req(ACT_TICK, 4'd0, 16'd0, 32'd0);
    queue_req(ACT_TICK, 4'd0, 16'd0, 32'd0);
    queue_req(ACT_ADD, 4'd0, 16'd3, $urandom);
    for (int i = 0; i < TABLE_SLOTS; i++) queue_req(ACT_RELEASE, 4'(i), 16'd0, 32'd0);
    wait_drained();
    burst_steady = 1'b0;

    // Random traffic, mostly well-formed, generated in batches against the shadow table
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued >= RANDOM_ITEMS / 2 && issued < RANDOM_ITEMS / 2 + 10) wait_settled();
      n_used = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) n_used += slot_used_q[i];
      for (int k = 0; k < 10; k++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          queue_req(ACT_TICK, 4'($urandom), 16'($urandom), $urandom);
        end else if (r < 55) begin
          r = $urandom_range(0, 9);
          secs = (r < 7) ? 16'($urandom_range(0, 6)) :
                 (r < 9) ? 16'($urandom_range(7, 40)) : 16'($urandom);
          queue_req(ACT_ADD, 4'($urandom), secs, $urandom);
        end else if (r < 88) begin
          queue_req(pick_slot_command(n_used), pick_used_slot(), 16'($urandom), $urandom);
        end else if (r < 96) begin
          queue_req(3'($urandom_range(ACT_CANCEL, ACT_RESUME)), 4'($urandom),
                    16'($urandom), $urandom);
        end else begin
          queue_req(($urandom_range(0, 1) != 0) ? ACT_UNUSED_6 : ACT_UNUSED_7,
                    4'($urandom), 16'($urandom), $urandom);
          issued--;
        end
        issued++;
      end
      wait_drained();
    end

    wait_settled();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin : watchdog
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
